// ===== design/sspq_pkg.sv =====
// Shared constants, codes and types for the stable sorted priority queue.
`default_nettype none

package sspq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned PRI_W    = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned ENT_W    = PRI_W + VAL_W;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_DATA_W  = ((PRI_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W  = 1 + VAL_W + PRI_W + CNT_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_RD,
    ST_ENQ_CMP,
    ST_DEQ_RD,
    ST_DEQ_WR,
    ST_FINISH
  } sspq_state_e;

endpackage

`default_nettype wire

// ===== design/stable_sorted_priority_queue_core.sv =====
// Top level of the stable sorted priority queue with a stepping insert/remove sequencer.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: entry_priority, entry_value
//  m_axis   out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: head and occupancy fields
//
//  Enqueue: each stored entry of greater priority moves up one slot, then the new one is written.
//  Dequeue: each later entry moves down one slot. A rejected command goes straight to the result.
//  One RAM port pair and one signed comparator step one slot at a time (read, then move).
//  Reset clears the entry count and the output valid flag; slot contents need no clearing.
//  s_axis_tready is high only while idle, re-entered as each result is loaded; a held result
//  stalls only the final load.
`default_nettype none

module stable_sorted_priority_queue_core
  import sspq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // entry_priority, entry_value
  input  wire logic [0:0]            s_axis_tuser,   // cmd
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,   // head_valid, head_value, head_priority,
                                                     // occupancy, full_flag, zero pad
  output      logic [STATUS_W-1:0]   m_axis_tuser    // status
);

  sspq_state_e state_q, state_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [PRI_W-1:0] pri_q, pri_d;
  logic [VAL_W-1:0]        val_q, val_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic signed [PRI_W-1:0] head_pri_q, head_pri_d;
  logic [VAL_W-1:0]        head_val_q, head_val_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [STATUS_W-1:0]   out_user_q, out_user_d;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ENT_W-1:0]      mem_rdata;

  logic                    in_xfer;
  logic [CNT_W-1:0]        idx_inc;
  logic signed [PRI_W-1:0] rd_pri;
  logic [VAL_W-1:0]        rd_val;
  logic                    rd_gt;
  logic                    out_free;
  logic                    head_valid;
  logic [OUT_RAW_W-1:0]    out_raw;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign idx_inc       = CNT_W'(idx_q) + CNT_W'(1);
  assign rd_pri        = mem_rdata[PRI_W-1:0];
  assign rd_val        = mem_rdata[ENT_W-1:PRI_W];
  assign rd_gt         = (rd_pri > pri_q);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign head_valid    = (count_q != '0);

  sspq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_raw = {(count_q == CNT_W'(CAPACITY)),
               count_q,
               head_valid ? head_pri_q : {PRI_W{1'b0}},
               head_valid ? head_val_q : {VAL_W{1'b0}},
               head_valid};
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    pri_d       = pri_q;
    val_d       = val_q;
    status_d    = status_q;
    head_pri_d  = head_pri_q;
    head_val_d  = head_val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = {val_q, pri_q};
    mem_raddr   = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pri_d    = s_axis_tdata[PRI_W-1:0];
          val_d    = s_axis_tdata[PRI_W+VAL_W-1:PRI_W];
          status_d = STATUS_DONE;
          if (s_axis_tuser[0] == CMD_ENQ) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = ST_FINISH;
            end else begin
              idx_d   = count_q[IDX_W-1:0];
              state_d = ST_ENQ_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = ST_FINISH;
            end else begin
              idx_d   = '0;
              state_d = ST_DEQ_RD;
            end
          end
        end
      end
      ST_ENQ_RD: begin
        if (idx_q == '0) begin
          mem_we     = 1'b1;
          head_pri_d = pri_q;
          head_val_d = val_q;
          count_d    = count_q + CNT_W'(1);
          state_d    = ST_FINISH;
        end else begin
          mem_raddr = idx_q - IDX_W'(1);
          state_d   = ST_ENQ_CMP;
        end
      end
      ST_ENQ_CMP: begin
        mem_we = 1'b1;
        if (rd_gt) begin
          mem_wdata = mem_rdata;
          idx_d     = idx_q - IDX_W'(1);
          state_d   = ST_ENQ_RD;
        end else begin
          count_d = count_q + CNT_W'(1);
          state_d = ST_FINISH;
        end
      end
      ST_DEQ_RD: begin
        if (idx_inc < count_q) begin
          mem_raddr = idx_inc[IDX_W-1:0];
          state_d   = ST_DEQ_WR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_FINISH;
        end
      end
      ST_DEQ_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (idx_q == '0) begin
          head_pri_d = rd_pri;
          head_val_d = rd_val;
        end
        idx_d   = idx_inc[IDX_W-1:0];
        state_d = ST_DEQ_RD;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[OUT_RAW_W-1:0] = out_raw;
          out_user_d  = status_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pri_q      <= pri_d;
    val_q      <= val_d;
    status_q   <= status_d;
    head_pri_q <= head_pri_d;
    head_val_q <= head_val_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> (count_q == $past(count_q)))
    else $error("entry count changed outside a command");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != ST_IDLE && state_q != ST_FINISH && state_q != ST_DEQ_RD))
    else $error("slot write outside a move step");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result loaded outside finish");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[OUT_RAW_W-1] ==
                     (out_data_q[OUT_RAW_W-2 -: CNT_W] == CNT_W'(CAPACITY))))
    else $error("full flag disagrees with occupancy");
`endif

endmodule

`default_nettype wire

// ===== design/sspq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module sspq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
